>>> hdl/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define BRG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define BRG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked on every rising edge outside reset
`define BRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/brg_pkg.sv
// types and constants of the bounded random generator
package brg_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned StateW = 64;

  // lcg multiplier 6364136223846793005 split into halves
  localparam logic [WordW-1:0] MultLo = 32'h4C95_7F2D;
  localparam logic [WordW-1:0] MultHi = 32'h5851_F42D;

  // xsh rr output permutation constants
  localparam int unsigned XshShift  = 18;
  localparam int unsigned XshDrop   = 27;
  localparam int unsigned RotMsb    = 63;
  localparam int unsigned RotLsb    = 59;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] divisor;
  } brg_mod_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] rem;
  } brg_mod_rsp_t;

  // xsh rr permutation of the pre-advance state
  function automatic logic [WordW-1:0] xsh_rr(input logic [StateW-1:0] old);
    logic [StateW-1:0]  mix;
    logic [WordW-1:0]   mixed;
    logic [4:0]         rot;
    logic [2*WordW-1:0] dbl;
    mix   = (old >> XshShift) ^ old;
    mixed = mix[XshDrop +: WordW];
    rot   = old[RotMsb:RotLsb];
    dbl   = {mixed, mixed} >> rot;
    return dbl[WordW-1:0];
  endfunction

endpackage

>>> hdl/brg_mul.sv
// shared 32x32 multiplier with registered product
module brg_mul
  import brg_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [WordW-1:0]    a_i,
  input  logic [WordW-1:0]    b_i,
  output logic [2*WordW-1:0]  p_o
);

  logic [2*WordW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= {{WordW{1'b0}}, a_i} * {{WordW{1'b0}}, b_i};
    end
  end

  assign p_o = p_q;

endmodule

>>> hdl/brg_mod.sv
// bit-serial unit for (2^32 - s) mod s, one quotient bit per cycle
module brg_mod
  import brg_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  brg_mod_req_t  req_i,
  output brg_mod_rsp_t  rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [4:0]           cnt_q;
  logic [WordW-1:0]     dvd_q;
  logic [WordW-1:0]     dsr_q;
  logic [WordW-1:0]     rem_q;
  logic [WordW:0]       shifted;
  logic [WordW:0]       diff;

  assign shifted = {rem_q, dvd_q[WordW-1]};
  assign diff    = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dsr_q <= req_i.divisor;
      dvd_q <= '0 - req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[WordW-2:0], 1'b0};
      // restore unless the trial subtract stays non-negative
      rem_q <= diff[WordW] ? shifted[WordW-1:0] : diff[WordW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> hdl/bounded_random_generator.sv
// an input beat is taken only in IDLE, and the next one only after the item has been
// handed to the output register; each draw makes four passes through the one 32x32
// multiplier, a rejection redraws, and the serial modulo runs at most once per item
// reset: generator state cleared to zero, no item in flight, output empty
// seed writes load the generator state directly
`include "assert_macros.svh"

module bounded_random_generator
  import brg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              seed_we_i,
  input  logic [StateW-1:0] seed_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [WordW-1:0]  bound_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WordW-1:0]  value_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_DIV,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [StateW-1:0]   gen_q;
  logic [StateW-1:0]   acc_q;
  logic [WordW-1:0]    bound_q;
  logic [WordW-1:0]    x_q;
  logic [2*WordW-1:0]  prod_q;
  logic [WordW-1:0]    thr_q;
  logic                have_thr_q;
  logic                mod_start_q;
  logic                out_valid_q;
  logic [WordW-1:0]    value_q;

  logic                mul_en;
  logic [WordW-1:0]    mul_a;
  logic [WordW-1:0]    mul_b;
  logic [2*WordW-1:0]  mul_p;
  brg_mod_req_t        mod_req;
  brg_mod_rsp_t        mod_rsp;

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = gen_q[WordW-1:0];
    mul_b  = MultLo;
    case (state_q)
      S_M0: begin
        mul_a = gen_q[WordW-1:0];
        mul_b = MultLo;
      end
      S_M1: begin
        mul_a = gen_q[StateW-1:WordW];
        mul_b = MultLo;
      end
      S_M2: begin
        mul_a = gen_q[WordW-1:0];
        mul_b = MultHi;
      end
      S_M3: begin
        mul_a = x_q;
        mul_b = bound_q;
      end
      default: mul_en = 1'b0;
    endcase
  end

  brg_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign mod_req.start   = mod_start_q;
  assign mod_req.divisor = bound_q;

  brg_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gen_q       <= '0;
      have_thr_q  <= 1'b0;
      mod_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mod_start_q <= 1'b0;
      // a finishing item refills the output register itself
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            bound_q    <= bound_i;
            have_thr_q <= 1'b0;
            state_q    <= S_M0;
          end
        end
        S_M0: begin
          x_q     <= xsh_rr(gen_q);
          state_q <= S_M1;
        end
        S_M1: begin
          acc_q   <= mul_p;
          state_q <= S_M2;
        end
        S_M2: begin
          acc_q[StateW-1:WordW] <= acc_q[StateW-1:WordW] + mul_p[WordW-1:0];
          state_q <= S_M3;
        end
        S_M3: begin
          acc_q[StateW-1:WordW] <= acc_q[StateW-1:WordW] + mul_p[WordW-1:0];
          state_q <= S_M4;
        end
        S_M4: begin
          prod_q <= mul_p;
          gen_q  <= acc_q + {{(StateW-1){1'b0}}, 1'b1};
          if (have_thr_q) begin
            state_q <= (mul_p[WordW-1:0] < thr_q) ? S_M0 : S_DONE;
          end else if (mul_p[WordW-1:0] < bound_q) begin
            // low word under the bound: need the rejection threshold
            mod_start_q <= 1'b1;
            state_q     <= S_DIV;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DIV: begin
          if (mod_rsp.done) begin
            thr_q      <= mod_rsp.rem;
            have_thr_q <= 1'b1;
            state_q    <= (prod_q[WordW-1:0] < mod_rsp.rem) ? S_M0 : S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            value_q     <= prod_q[2*WordW-1:WordW];
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (seed_we_i) begin
        gen_q <= seed_i;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  `BRG_ASSERT_IMPL(a_rem_below_bound, clk_i, rst_ni, mod_rsp.done, mod_rsp.rem < bound_q,
                   "threshold not below bound")
  `BRG_ASSERT_IMPL(a_result_in_range, clk_i, rst_ni, state_q == S_DONE && bound_q != '0,
                   prod_q[2*WordW-1:WordW] < bound_q, "result not below bound")
  `BRG_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && in_ready_o,
                   state_q == S_M0, "accepted beat did not start a draw")
  `BRG_ASSERT_IMPL(a_out_from_done, clk_i, rst_ni, $rose(out_valid_o),
                   $past(state_q == S_DONE), "output beat without finished item")

endmodule
